/* hw/rtl/pfb_pkg.sv */
`default_nettype none

package pfb_pkg;

  // Image geometry. Pixels are stored as vertical pages of eight rows each,
  // with the top row of a page in bit 0.
  localparam int NUM_COLS    = 128;
  localparam int NUM_ROWS    = 64;
  localparam int PAGE_BITS   = 8;
  localparam int MAX_PAGES   = 8;
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [7:0] COLS_VAL     = 8'(NUM_COLS);
  localparam logic [6:0] ROWS_VAL     = 7'(NUM_ROWS);
  localparam logic [3:0] MAX_PAGES_C  = 4'(MAX_PAGES);
  localparam logic [7:0] MARGIN_RESET = 8'd128;

  // Operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // Pixel write modes.
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_SET   = 2'd1;
  localparam logic [1:0] MODE_FLIP  = 2'd2;
  localparam logic [1:0] MODE_KEEP  = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_WRITE_DONE = 2'd0;
  localparam logic [1:0] KIND_READ_VALUE = 2'd1;
  localparam logic [1:0] KIND_FLUSH_BYTE = 2'd2;
  localparam logic [1:0] KIND_NOTHING    = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] pixel_row;
    logic [7:0] pixel_column;
    logic [1:0] pixel_mode;
  } pfb_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] page_index;
    logic [6:0] column_index;
    logic [7:0] data_byte;
    logic       more_pending;
    logic       last;
  } pfb_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear_step;
    logic do_write;
    logic do_read;
    logic flush_setup;
    logic flush_issue;
  } pfb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic rect_empty;
    logic page_last;
  } pfb_status_t;

  // Byte address of (page, column) in the frame store.
  function automatic logic [ADDR_W-1:0] store_addr(input logic [3:0] page,
                                                   input logic [7:0] col);
    logic [31:0] sum;
    sum = 32'(page) * 32'(NUM_COLS) + 32'(col);
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pfb_ctrl.sv */
`default_nettype none

module pfb_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [1:0]           operation,
  input  wire pfb_pkg::pfb_status_t status,
  output pfb_pkg::pfb_cmd_t         cmd,
  output logic                      busy
);

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_WRITE    = 6'b000100,
    S_READ     = 6'b001000,
    S_FL_SETUP = 6'b010000,
    S_FL_ISSUE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          unique case (operation)
            pfb_pkg::OP_WRITE: state_next = S_WRITE;
            pfb_pkg::OP_READ:  state_next = S_READ;
            pfb_pkg::OP_FLUSH: state_next = S_FL_SETUP;
            default:           state_next = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.do_write = 1'b1;
        state_next   = S_IDLE;
      end
      S_READ: begin
        cmd.do_read = 1'b1;
        state_next  = S_IDLE;
      end
      S_FL_SETUP: begin
        cmd.flush_setup = 1'b1;
        state_next      = status.rect_empty ? S_IDLE : S_FL_ISSUE;
      end
      S_FL_ISSUE: begin
        cmd.flush_issue = 1'b1;
        if (status.page_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/pfb_datapath.sv */
`default_nettype none

module pfb_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pfb_pkg::pfb_item_t   item,
  input  wire logic                 config_we,
  input  wire logic [7:0]           config_data,
  input  wire pfb_pkg::pfb_cmd_t    cmd,
  output pfb_pkg::pfb_status_t      status,
  output pfb_pkg::pfb_result_t      result,
  output logic                      strobe
);

  // Frame store, one byte per (page, column).
  logic [7:0] mem [pfb_pkg::STORE_DEPTH];
  logic [7:0] rd_data;
  logic [pfb_pkg::ADDR_W-1:0] rd_addr;
  logic [pfb_pkg::ADDR_W-1:0] wr_addr;
  logic [7:0] wr_data;
  logic       wr_en;

  // Configuration and dirty rectangle.
  logic [7:0] right_margin;
  logic [6:0] first_row;
  logic [6:0] end_row;
  logic [7:0] first_col;
  logic [7:0] end_col;
  logic [7:0] cursor;
  logic [pfb_pkg::ADDR_W-1:0] clear_addr;

  // Accepted item.
  pfb_pkg::pfb_item_t item_q;
  logic [pfb_pkg::ADDR_W-1:0] item_addr;

  // Flush walk.
  logic [7:0] fl_col;
  logic [3:0] fl_page;
  logic [3:0] fl_end;
  logic       fl_more;
  logic       pipe_valid;
  logic [2:0] pipe_page;
  logic       pipe_last;

  pfb_pkg::pfb_result_t result_next;
  logic                 strobe_next;

  logic [7:0] eff_margin;
  logic       wr_in_range;
  logic [7:0] bit_mask;
  logic [7:0] new_byte;
  logic       wr_change;
  logic       rd_in_range;
  logic       rect_empty;
  logic       cur_in;
  logic [7:0] cur_sel;
  logic [7:0] first_col_adv;
  logic       setup_more;
  logic [7:0] er_plus;
  logic [4:0] end_pg_raw;
  logic [3:0] end_pg;
  logic       page_last;

  assign eff_margin  = (right_margin < pfb_pkg::COLS_VAL) ? right_margin : pfb_pkg::COLS_VAL;
  assign wr_in_range = (item_q.pixel_row < pfb_pkg::ROWS_VAL) &&
                       (item_q.pixel_column < eff_margin);
  assign bit_mask    = 8'd1 << item_q.pixel_row[2:0];

  always_comb begin
    case (item_q.pixel_mode)
      pfb_pkg::MODE_CLEAR: new_byte = rd_data & ~bit_mask;
      pfb_pkg::MODE_SET:   new_byte = rd_data | bit_mask;
      pfb_pkg::MODE_FLIP:  new_byte = rd_data ^ bit_mask;
      default:             new_byte = rd_data;
    endcase
  end

  assign wr_change   = wr_in_range && (new_byte != rd_data);
  assign rd_in_range = (item_q.pixel_row < pfb_pkg::ROWS_VAL) &&
                       (item_q.pixel_column < pfb_pkg::COLS_VAL);

  // A flush restarts at the first dirty column when the cursor has left the
  // rectangle, and the rectangle's left edge moves past the walked column
  // when that column is the left edge.
  assign rect_empty    = !((end_col > first_col) && (end_row > first_row));
  assign cur_in        = (cursor >= first_col) && (cursor < end_col);
  assign cur_sel       = cur_in ? cursor : first_col;
  assign first_col_adv = (cur_sel == first_col) ? first_col + 8'd1 : first_col;
  assign setup_more    = (first_col_adv != end_col);
  assign er_plus       = {1'b0, end_row} + 8'd7;
  assign end_pg_raw    = er_plus[7:3];
  assign end_pg        = (end_pg_raw > 5'(pfb_pkg::MAX_PAGES)) ? pfb_pkg::MAX_PAGES_C
                                                                : end_pg_raw[3:0];
  assign page_last     = ((fl_page + 4'd1) == fl_end);

  assign status.clear_last = &clear_addr;
  assign status.rect_empty = rect_empty;
  assign status.page_last  = page_last;

  // Memory ports.
  assign rd_addr = cmd.flush_issue ? pfb_pkg::store_addr(fl_page, fl_col)
                                   : pfb_pkg::store_addr(item.pixel_row[6:3],
                                                         item.pixel_column);
  assign wr_en   = cmd.clear_step || (cmd.do_write && wr_change);
  assign wr_addr = cmd.clear_step ? clear_addr : item_addr;
  assign wr_data = cmd.clear_step ? 8'd0 : new_byte;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_margin <= pfb_pkg::MARGIN_RESET;
      first_row    <= pfb_pkg::ROWS_VAL;
      first_col    <= pfb_pkg::COLS_VAL;
      end_row      <= 7'd0;
      end_col      <= 8'd0;
      cursor       <= 8'd0;
      clear_addr   <= '0;
      fl_page      <= 4'd0;
      pipe_valid   <= 1'b0;
    end else begin
      if (config_we) begin
        right_margin <= config_data;
      end
      if (cmd.clear_step) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (cmd.do_write && wr_change) begin
        if (item_q.pixel_column < first_col) begin
          first_col <= item_q.pixel_column;
        end
        if (item_q.pixel_column >= end_col) begin
          end_col <= item_q.pixel_column + 8'd1;
        end
        if (item_q.pixel_row < first_row) begin
          first_row <= item_q.pixel_row;
        end
        if (item_q.pixel_row >= end_row) begin
          end_row <= item_q.pixel_row + 7'd1;
        end
      end
      if (cmd.flush_setup && !rect_empty) begin
        fl_page <= first_row[6:3];
        if (setup_more) begin
          first_col <= first_col_adv;
          cursor    <= cur_sel + 8'd1;
        end else begin
          first_row <= pfb_pkg::ROWS_VAL;
          first_col <= pfb_pkg::COLS_VAL;
          end_row   <= 7'd0;
          end_col   <= 8'd0;
          cursor    <= 8'd0;
        end
      end else if (cmd.flush_issue) begin
        fl_page <= fl_page + 4'd1;
      end
      pipe_valid <= cmd.flush_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_q    <= item;
      item_addr <= rd_addr;
    end
    if (cmd.flush_setup) begin
      fl_col  <= cur_sel;
      fl_end  <= end_pg;
      fl_more <= setup_more;
    end
    pipe_page <= fl_page[2:0];
    pipe_last <= page_last;
  end

  always_comb begin
    strobe_next = 1'b0;
    result_next = '0;
    if (cmd.do_write) begin
      strobe_next      = 1'b1;
      result_next.kind = pfb_pkg::KIND_WRITE_DONE;
      result_next.last = 1'b1;
    end else if (cmd.do_read) begin
      strobe_next           = 1'b1;
      result_next.kind      = pfb_pkg::KIND_READ_VALUE;
      result_next.data_byte = {7'd0, rd_in_range & rd_data[item_q.pixel_row[2:0]]};
      result_next.last      = 1'b1;
    end else if (cmd.flush_setup && rect_empty) begin
      strobe_next      = 1'b1;
      result_next.kind = pfb_pkg::KIND_NOTHING;
      result_next.last = 1'b1;
    end else if (pipe_valid) begin
      strobe_next              = 1'b1;
      result_next.kind         = pfb_pkg::KIND_FLUSH_BYTE;
      result_next.page_index   = pipe_page;
      result_next.column_index = fl_col[6:0];
      result_next.data_byte    = rd_data;
      result_next.more_pending = fl_more;
      result_next.last         = pipe_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

`ifndef ASSERT_OFF
  a_rect_bounds: assert property (@(posedge clk) disable iff (rst)
    (end_col <= pfb_pkg::COLS_VAL) && (end_row <= pfb_pkg::ROWS_VAL))
    else $error("dirty rectangle beyond the image");

  a_page_in_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.flush_issue |-> (fl_page < fl_end))
    else $error("flush page past its end page");

  a_write_answer: assert property (@(posedge clk) disable iff (rst)
    cmd.do_write |=> (strobe && (result.kind == pfb_pkg::KIND_WRITE_DONE)))
    else $error("write without its answer");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (pipe_valid && pipe_last) |=> !pipe_valid)
    else $error("flush byte after the last one");
`endif

endmodule

`default_nettype wire

/* hw/rtl/paged_framebuffer_dirty_flush.sv */
// Write and read pixel items: accepted when start is high and busy low; the
// one result is registered from the WRITE or READ state, and busy stays high until then.
// Flush items walk the N dirty pages of one column, one store read per cycle through
// the single read port; the bytes strobe on consecutive cycles after the setup state.
// Results are never stalled. Synchronous reset starts a clearing pass of all 1024
// bytes of the frame store with busy high; margin writes are taken throughout.
`default_nettype none

module paged_framebuffer_dirty_flush (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire pfb_pkg::pfb_item_t   item,
  input  wire logic                 config_we,
  input  wire logic [7:0]           config_data,
  output logic                      strobe,
  output pfb_pkg::pfb_result_t      result
);

  // The controller sequences the clearing pass, the pixel read-modify-write
  // and the page walk of a flush. Everything it steers goes through this
  // command beat and the status bits that come back.
  pfb_pkg::pfb_cmd_t    cmd;
  pfb_pkg::pfb_status_t status;

  pfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (item.operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // The datapath holds the frame store, the dirty rectangle, the flush
  // cursor and the registered result beat. Each result stands on the
  // outputs for exactly one cycle while strobe is high.
  pfb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .config_we   (config_we),
    .config_data (config_data),
    .cmd         (cmd),
    .status      (status),
    .result      (result),
    .strobe      (strobe)
  );

endmodule

`default_nettype wire
